FILE: src/mvs_pkg.sv
// Shared types and constants for the measured value scaler.
// Holds mode, status and register-index codes plus the config and sideband structs.
// No dependencies.
package mvs_pkg;

  localparam int SAMPLE_W = 32;
  localparam int ROOT_W   = 32;
  localparam int RAD_W    = 2 * ROOT_W;
  localparam int REM_W    = ROOT_W + 3;
  localparam int WIDE_W   = 64;

  localparam logic [1:0] MODE_PASS        = 2'd0;
  localparam logic [1:0] MODE_LINEAR      = 2'd1;
  localparam logic [1:0] MODE_GAIN_ROOT   = 2'd2;
  localparam logic [1:0] MODE_ROOT_LINEAR = 2'd3;

  localparam logic [1:0] STATUS_OK           = 2'd0;
  localparam logic [1:0] STATUS_DEADBAND     = 2'd1;
  localparam logic [1:0] STATUS_INCONSISTENT = 2'd2;
  localparam logic [1:0] STATUS_OVERFLOW     = 2'd3;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DB_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DB_HIGH = 3'd4;

  typedef struct packed {
    logic [1:0]          mode;
    logic [SAMPLE_W-1:0] gain;
    logic [SAMPLE_W-1:0] offset;
    logic [SAMPLE_W-1:0] db_low;
    logic [SAMPLE_W-1:0] db_high;
  } mvs_cfg_t;

  // Travels alongside the root pipeline
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [1:0]          mode;
    logic                in_band;
    logic [WIDE_W-1:0]   sum;
  } mvs_side_t;

endpackage

FILE: src/measured_value_scaler.sv
// Channel   Dir  Payload                                   Handshake
// s_axis    in   tdata[31:0] sample (signed Q format)      tvalid/tready
// m_axis    out  tdata[31:0] scaled, tuser[1:0] status     tvalid/tready
// cfg       in   cfg_index selects register, cfg_data      cfg_we, no wait
//
// One request accepted per cycle unless m_axis stalls; the pipeline holds three front stages,
// 32 stages of the bit-per-stage square root, the gain multiply and the
// output register. The root pipeline sets the depth.
// rst is synchronous and clears all valid bits and the config registers.
// A stall on m_axis freezes the whole pipeline; s_axis_tready drops with it.
//
// Top level: config registers, pipeline enable and the three pipeline parts.
// Depends on mvs_pkg, mvs_front, mvs_sqrt, mvs_back.
module measured_value_scaler import mvs_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [SAMPLE_W-1:0]  s_axis_tdata,   // [31:0] sample
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [SAMPLE_W-1:0]  m_axis_tdata,   // [31:0] scaled
  output logic [1:0]           m_axis_tuser,   // [1:0] status
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SAMPLE_W-1:0]  cfg_data
);

  localparam logic [SAMPLE_W-1:0] GAIN_ONE = SAMPLE_W'(64'd1 << FRACTION_BITS);

  mvs_cfg_t          cfg;
  logic              ce;

  logic              f_valid;
  mvs_side_t         f_side;
  logic [RAD_W-1:0]  f_rad;

  logic              r_valid;
  mvs_side_t         r_side;
  logic [ROOT_W-1:0] r_root;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode    <= MODE_PASS;
      cfg.gain    <= GAIN_ONE;
      cfg.offset  <= '0;
      cfg.db_low  <= '0;
      cfg.db_high <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:    cfg.mode    <= cfg_data[1:0];
        REG_GAIN:    cfg.gain    <= cfg_data;
        REG_OFFSET:  cfg.offset  <= cfg_data;
        REG_DB_LOW:  cfg.db_low  <= cfg_data;
        REG_DB_HIGH: cfg.db_high <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Advance everything unless a finished result is still waiting
  assign ce            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = ce;

  mvs_front #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_sample (s_axis_tdata),
    .out_valid (f_valid),
    .out_side  (f_side),
    .out_rad   (f_rad)
  );

  mvs_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (f_valid),
    .in_side   (f_side),
    .in_rad    (f_rad),
    .out_valid (r_valid),
    .out_side  (r_side),
    .out_root  (r_root)
  );

  mvs_back #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .ce         (ce),
    .cfg        (cfg),
    .in_valid   (r_valid),
    .in_side    (r_side),
    .in_root    (r_root),
    .out_valid  (m_axis_tvalid),
    .out_scaled (m_axis_tdata),
    .out_status (m_axis_tuser)
  );

endmodule

FILE: src/mvs_front.sv
// Front end: sample capture, deadband compare and gain product, then offset add.
// Builds the radicand for the root pipeline. Depends on mvs_pkg.
module mvs_front import mvs_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                ce,
  input  mvs_cfg_t            cfg,
  input  logic                in_valid,
  input  logic [SAMPLE_W-1:0] in_sample,
  output logic                out_valid,
  output mvs_side_t           out_side,
  output logic [RAD_W-1:0]    out_rad
);

  localparam logic [WIDE_W-1:0] HALF = 64'd1 << (FRACTION_BITS - 1);

  logic                       s1_valid;
  logic [SAMPLE_W-1:0]        s1_sample;

  logic                       s2_valid;
  logic [SAMPLE_W-1:0]        s2_sample;
  logic [1:0]                 s2_mode;
  logic                       s2_inside;
  logic signed [WIDE_W-1:0]   s2_prod;

  logic signed [WIDE_W-1:0]   prod_next;
  logic                       inside_next;
  logic [WIDE_W-1:0]          addend;
  logic [WIDE_W-1:0]          sum_next;
  logic [RAD_W-1:0]           rad_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (ce) begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  always_comb begin
    prod_next   = $signed(cfg.gain) * $signed(s1_sample);
    inside_next = ($signed(s1_sample) > $signed(cfg.db_low)) &&
                  ($signed(s1_sample) < $signed(cfg.db_high));
  end

  // Offset moved up to the product scale; in linear mode the rounding half sits below it
  always_comb begin
    addend = WIDE_W'($signed(cfg.offset)) << FRACTION_BITS;
    if (s2_mode == MODE_LINEAR) begin
      addend = addend | HALF;
    end
    sum_next = s2_prod + addend;
    if (s2_mode == MODE_GAIN_ROOT) begin
      rad_next = {{(RAD_W-SAMPLE_W){1'b0}}, s2_sample} << FRACTION_BITS;
    end else begin
      rad_next = sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s1_sample        <= in_sample;
      s2_sample        <= s1_sample;
      s2_mode          <= cfg.mode;
      s2_inside        <= inside_next;
      s2_prod          <= prod_next;
      out_side.sample  <= s2_sample;
      out_side.mode    <= s2_mode;
      out_side.in_band <= s2_inside;
      out_side.sum     <= sum_next;
      out_rad          <= rad_next;
    end
  end

endmodule

FILE: src/mvs_sqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Carries the sideband struct along with the radicand. Depends on mvs_pkg.
module mvs_sqrt import mvs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              ce,
  input  logic              in_valid,
  input  mvs_side_t         in_side,
  input  logic [RAD_W-1:0]  in_rad,
  output logic              out_valid,
  output mvs_side_t         out_side,
  output logic [ROOT_W-1:0] out_root
);

  logic              valid [0:ROOT_W];
  mvs_side_t         side  [0:ROOT_W];
  logic [RAD_W-1:0]  rad   [0:ROOT_W];
  logic [REM_W-1:0]  rem   [0:ROOT_W];
  logic [ROOT_W-1:0] root  [0:ROOT_W];

  assign valid[0] = in_valid;
  assign side[0]  = in_side;
  assign rad[0]   = in_rad;
  assign rem[0]   = '0;
  assign root[0]  = '0;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             take;

    // Bring down the next two radicand bits and try the next root bit
    always_comb begin
      rem_sh = {rem[k][REM_W-3:0], rad[k][RAD_W-1 -: 2]};
      trial  = {1'b0, root[k], 2'b01};
      take   = rem_sh >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k+1] <= 1'b0;
      end else if (ce) begin
        valid[k+1] <= valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        side[k+1] <= side[k];
        rad[k+1]  <= rad[k] << 2;
        rem[k+1]  <= take ? (rem_sh - trial) : rem_sh;
        root[k+1] <= {root[k][ROOT_W-2:0], take};
      end
    end
  end

  assign out_valid = valid[ROOT_W];
  assign out_side  = side[ROOT_W];
  assign out_root  = root[ROOT_W];

endmodule

FILE: src/mvs_back.sv
// Back end: gain times root, offset add with rounding, range check and result select.
// Ends in the output register. Depends on mvs_pkg.
module mvs_back import mvs_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                ce,
  input  mvs_cfg_t            cfg,
  input  logic                in_valid,
  input  mvs_side_t           in_side,
  input  logic [ROOT_W-1:0]   in_root,
  output logic                out_valid,
  output logic [SAMPLE_W-1:0] out_scaled,
  output logic [1:0]          out_status
);

  localparam logic [WIDE_W-1:0] HALF = 64'd1 << (FRACTION_BITS - 1);

  logic                     m_valid;
  mvs_side_t                m_side;
  logic [ROOT_W-1:0]        m_root;
  logic signed [WIDE_W-1:0] m_prod;

  logic signed [WIDE_W-1:0] prod_next;
  logic signed [WIDE_W-1:0] sum2;
  logic signed [WIDE_W-1:0] val;
  logic                     arg_bad;
  logic                     fits;
  logic [SAMPLE_W-1:0]      scaled_next;
  logic [1:0]               status_next;

  always_comb begin
    prod_next = WIDE_W'($signed(cfg.gain) * $signed({1'b0, in_root}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (ce) begin
      m_valid   <= in_valid;
      out_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m_side <= in_side;
      m_root <= in_root;
      m_prod <= prod_next;
    end
  end

  always_comb begin
    sum2    = m_prod + ((WIDE_W'($signed(cfg.offset)) << FRACTION_BITS) | HALF);
    arg_bad = 1'b0;
    case (m_side.mode)
      MODE_PASS: begin
        val = WIDE_W'($signed(m_side.sample));
      end
      MODE_LINEAR: begin
        val = $signed(m_side.sum) >>> FRACTION_BITS;
      end
      MODE_GAIN_ROOT: begin
        val     = sum2 >>> FRACTION_BITS;
        arg_bad = $signed(m_side.sample) <= 0;
      end
      MODE_ROOT_LINEAR: begin
        val     = {{(WIDE_W-ROOT_W){1'b0}}, m_root};
        arg_bad = $signed(m_side.sum) <= 0;
      end
      default: begin
        val = WIDE_W'($signed(m_side.sample));
      end
    endcase
    fits = (val[WIDE_W-1:SAMPLE_W-1] == '0) || (val[WIDE_W-1:SAMPLE_W-1] == '1);

    if (m_side.in_band) begin
      scaled_next = m_side.sample;
      status_next = STATUS_DEADBAND;
    end else if (arg_bad) begin
      scaled_next = '0;
      status_next = STATUS_INCONSISTENT;
    end else if (!fits) begin
      scaled_next = '0;
      status_next = STATUS_OVERFLOW;
    end else begin
      scaled_next = val[SAMPLE_W-1:0];
      status_next = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_scaled <= scaled_next;
      out_status <= status_next;
    end
  end

endmodule
